### design/gblur_pkg.sv
// ============================================================================
// gblur_pkg - shared constants and types for the 3x3 Gaussian blur stream
// Field widths, register map, result record and output queue sizing.
// ============================================================================
package gblur_pkg;

    // default geometry limits handed to the top level
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    // payload and arithmetic widths
    localparam int PIX_W     = 8;   // one image component
    localparam int HSUM_W    = 10;  // horizontal 1-2-1 sum, at most 4 * 255
    localparam int SUM_W     = 12;  // full 3x3 weighted sum, at most 16 * 255
    localparam int SUM_SHIFT = 4;   // divide by 16
    localparam int ROW_W     = 16;
    localparam int COL_W     = 11;
    localparam int CHAN_W    = 2;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int WIDTH_REG_W = 12;
    localparam int CHANS_REG_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_IMAGE_WIDTH   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_IMAGE_HEIGHT  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_CHANNEL_COUNT = cfg_idx_t'(2);

    localparam logic [WIDTH_REG_W-1:0] RST_IMAGE_WIDTH   = WIDTH_REG_W'(640);
    localparam logic [ROW_W-1:0]       RST_IMAGE_HEIGHT  = ROW_W'(480);
    localparam logic [CHANS_REG_W-1:0] RST_CHANNEL_COUNT = CHANS_REG_W'(3);

    // result queue: room for two results per operation in flight
    localparam int FIFO_DEPTH       = 8;
    localparam int FIFO_AW          = 3;
    localparam int FIFO_CW          = 4;
    localparam int FIFO_ISSUE_LIMIT = FIFO_DEPTH - 4;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAN_W-1:0] chan;
        logic              done;
    } result_t;

endpackage

### design/gaussian_blur_3x3_stream.sv
// ============================================================================
// gaussian_blur_3x3_stream - streaming separable 3x3 Gaussian blur
// Takes one 8-bit component per request in raster order, channels
// interleaved, and gives each blurred component (1-2-1 by 1-2-1, divided by
// 16 and truncated, edges clamped) with its row, column and channel. One
// input request is taken every clock while in_stall is low. Each component
// of the last column of a row wider than one column needs two operations on
// the line memory and stalls the input until the second issues; the single
// result port then sets the pace where one component releases more than one
// result (two at the end of a later row and past the first column of the
// last row of a frame, up to four at the end of the frame). The horizontal
// sums of the two previous rows sit in one synchronous memory of
// MAX_WIDTH * MAX_CHANNELS words of 20 bits that is read, updated and
// written back once per operation; it needs no clearing after reset. A small
// queue of eight results decouples the output side.
// ============================================================================
module gaussian_blur_3x3_stream
    import gblur_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // input component stream
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,
    // result stream
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,
    output logic [CHAN_W-1:0]     out_channel,
    output logic                  frame_done,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int CH_CW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W      = $clog2(MAX_CHANNELS + 1);
    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LINE_W     = 2 * HSUM_W;

    // one read-modify-write operation on the line memory
    typedef struct packed {
        logic [HSUM_W-1:0]  hsum;
        logic [LINE_AW-1:0] addr;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [CHAN_W-1:0]  chan;
        logic               emit_up;    // row above is complete
        logic               up_newer;   // top edge: row above clamps to newer line
        logic               emit_last;  // this is the last row of the frame
        logic               last_self;  // first row: in a single-row frame the row above clamps to this one
        logic               done;       // final result of the frame
    } hop_t;

    // ------------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0] width_cfg_reg;
    logic [ROW_W-1:0]       height_cfg_reg;
    logic [CHANS_REG_W-1:0] chans_cfg_reg;

    logic [WID_W-1:0]       width_eff;
    logic [ROW_W-1:0]       height_eff;
    logic [NCH_W-1:0]       chans_eff;

    logic [CH_CW-1:0]       chan_cnt_reg, chan_cnt_next;
    logic [COL_CW-1:0]      col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]       row_cnt_reg, row_cnt_next;
    logic [CH_CW-1:0]       cur_ch;
    logic [COL_CW-1:0]      cur_col;
    logic [ROW_W-1:0]       cur_row;
    logic                   last_chan, last_col, last_row, col_first;

    logic [PIX_W-1:0]       prev_a_reg [MAX_CHANNELS];
    logic [PIX_W-1:0]       prev_b_reg [MAX_CHANNELS];
    logic [PIX_W-1:0]       comp_a, comp_b;
    logic [HSUM_W-1:0]      hsum_mid, hsum_end;
    hop_t                   op_mid, op_end;

    hop_t                   hop0_reg, hop0_next, hop1_reg, hop1_next;
    logic                   hop0_valid_reg, hop0_valid_next;
    logic                   hop1_valid_reg, hop1_valid_next;
    logic                   issue, in_ready, accept;

    logic [LINE_W-1:0]      line_mem [LINE_DEPTH];
    logic [LINE_W-1:0]      line_rd_reg;
    logic                   rs_valid_reg;
    hop_t                   rs_op_reg;
    logic                   fwd_hit_reg;
    logic [LINE_W-1:0]      fwd_data_reg;
    logic [LINE_W-1:0]      line_rdata, line_wdata;
    logic [HSUM_W-1:0]      old_older, old_newer, up_a, up_b;
    logic [SUM_W-1:0]       sum_up, sum_last;
    result_t                res_up, res_last;

    result_t                fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     head_reg, head_next, tail_reg, tail_next, last_slot;
    logic [FIFO_CW-1:0]     fifo_cnt_reg, fifo_cnt_next, n_push;
    logic                   push_up, push_last, pop;
    result_t                head_res;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RST_IMAGE_WIDTH;
            height_cfg_reg <= RST_IMAGE_HEIGHT;
            chans_cfg_reg  <= RST_CHANNEL_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_cfg_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT:  height_cfg_reg <= cfg_data[ROW_W-1:0];
                REG_CHANNEL_COUNT: chans_cfg_reg  <= cfg_data[CHANS_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    // clamp geometry to the supported range
    always_comb
    begin
        if (width_cfg_reg == '0)
            width_eff = WID_W'(1);
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            width_eff = WID_W'(MAX_WIDTH);
        else
            width_eff = WID_W'(width_cfg_reg);

        height_eff = (height_cfg_reg == '0) ? ROW_W'(1) : height_cfg_reg;

        if (chans_cfg_reg == '0)
            chans_eff = NCH_W'(1);
        else if (32'(chans_cfg_reg) > MAX_CHANNELS)
            chans_eff = NCH_W'(MAX_CHANNELS);
        else
            chans_eff = NCH_W'(chans_cfg_reg);
    end

    // ------------------------------------------------------------------------
    // position of the incoming component
    // ------------------------------------------------------------------------
    always_comb
    begin
        cur_ch    = (32'(chan_cnt_reg) >= 32'(chans_eff))  ? '0 : chan_cnt_reg;
        cur_col   = (32'(col_cnt_reg)  >= 32'(width_eff))  ? '0 : col_cnt_reg;
        cur_row   = (32'(row_cnt_reg)  >= 32'(height_eff)) ? '0 : row_cnt_reg;
        last_chan = (32'(cur_ch)  + 1) >= 32'(chans_eff);
        last_col  = (32'(cur_col) + 1) >= 32'(width_eff);
        last_row  = (32'(cur_row) + 1) >= 32'(height_eff);
        col_first = (cur_col == '0);

        chan_cnt_next = chan_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        if (accept)
        begin
            col_cnt_next = cur_col;
            row_cnt_next = cur_row;
            if (last_chan)
            begin
                chan_cnt_next = '0;
                if (last_col)
                begin
                    col_cnt_next = '0;
                    row_cnt_next = last_row ? '0 : ROW_W'(32'(cur_row) + 1);
                end
                else
                begin
                    col_cnt_next = COL_CW'(32'(cur_col) + 1);
                end
            end
            else
            begin
                chan_cnt_next = CH_CW'(32'(cur_ch) + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg <= '0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            chan_cnt_reg <= chan_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------------
    // horizontal pass: last two components of each channel
    // ------------------------------------------------------------------------
    always_comb
    begin
        comp_a   = col_first ? pixel_in : prev_a_reg[cur_ch];
        comp_b   = col_first ? pixel_in : prev_b_reg[cur_ch];
        hsum_mid = HSUM_W'(comp_b) + HSUM_W'({comp_a, 1'b0}) + HSUM_W'(pixel_in);
        hsum_end = HSUM_W'(comp_a) + HSUM_W'({pixel_in, 1'b0}) + HSUM_W'(pixel_in);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_b_reg[cur_ch] <= comp_a;
            prev_a_reg[cur_ch] <= pixel_in;
        end
    end

    // build the line operations for the previous and the current column
    always_comb
    begin
        op_mid.hsum      = hsum_mid;
        op_mid.addr      = LINE_AW'((32'(cur_col) - 1) * MAX_CHANNELS + 32'(cur_ch));
        op_mid.row       = cur_row;
        op_mid.col       = COL_W'(32'(cur_col) - 1);
        op_mid.chan      = CHAN_W'(cur_ch);
        op_mid.emit_up   = (cur_row != '0);
        op_mid.up_newer  = (cur_row == ROW_W'(1));
        op_mid.emit_last = last_row;
        op_mid.last_self = (cur_row == '0);
        op_mid.done      = 1'b0;

        op_end           = op_mid;
        op_end.hsum      = hsum_end;
        op_end.addr      = LINE_AW'(32'(cur_col) * MAX_CHANNELS + 32'(cur_ch));
        op_end.col       = COL_W'(cur_col);
        op_end.done      = last_row && last_chan;
    end

    // ------------------------------------------------------------------------
    // pending operations and input handshake
    // ------------------------------------------------------------------------
    assign issue    = hop0_valid_reg && (fifo_cnt_reg <= FIFO_CW'(FIFO_ISSUE_LIMIT));
    assign in_ready = !hop0_valid_reg || (issue && !hop1_valid_reg);
    assign in_stall = !in_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hop0_next       = hop0_reg;
        hop1_next       = hop1_reg;
        hop0_valid_next = hop0_valid_reg;
        hop1_valid_next = hop1_valid_reg;
        // advance the second slot when the first issues
        if (issue)
        begin
            hop0_next       = hop1_reg;
            hop0_valid_next = hop1_valid_reg;
            hop1_valid_next = 1'b0;
        end
        // load the operations of a newly taken component
        if (accept)
        begin
            if (!col_first)
            begin
                hop0_next       = op_mid;
                hop0_valid_next = 1'b1;
                hop1_next       = op_end;
                hop1_valid_next = last_col;
            end
            else
            begin
                hop0_next       = op_end;
                hop0_valid_next = last_col;
                hop1_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop0_valid_reg <= 1'b0;
            hop1_valid_reg <= 1'b0;
            rs_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            hop0_valid_reg <= hop0_valid_next;
            hop1_valid_reg <= hop1_valid_next;
            rs_valid_reg   <= issue;
            // catch a read of the entry being written back in the same cycle
            fwd_hit_reg    <= issue && rs_valid_reg && (rs_op_reg.addr == hop0_reg.addr);
        end
    end

    always_ff @(posedge clk)
    begin
        hop0_reg     <= hop0_next;
        hop1_reg     <= hop1_next;
        fwd_data_reg <= line_wdata;
        if (issue)
            rs_op_reg <= hop0_reg;
    end

    // ------------------------------------------------------------------------
    // line memory: read on issue, write back in the following cycle
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (issue)
            line_rd_reg <= line_mem[hop0_reg.addr];
        if (rs_valid_reg)
            line_mem[rs_op_reg.addr] <= line_wdata;
    end

    // vertical pass and write-back data
    always_comb
    begin
        line_rdata = fwd_hit_reg ? fwd_data_reg : line_rd_reg;
        old_older  = line_rdata[LINE_W-1:HSUM_W];
        old_newer  = line_rdata[HSUM_W-1:0];
        line_wdata = {old_newer, rs_op_reg.hsum};

        up_a   = rs_op_reg.up_newer ? old_newer : old_older;
        sum_up = SUM_W'(up_a) + SUM_W'({old_newer, 1'b0}) + SUM_W'(rs_op_reg.hsum);

        up_b     = rs_op_reg.last_self ? rs_op_reg.hsum : old_newer;
        sum_last = SUM_W'(up_b) + SUM_W'({rs_op_reg.hsum, 1'b0}) + SUM_W'(rs_op_reg.hsum);

        res_up.pixel = PIX_W'(sum_up >> SUM_SHIFT);
        res_up.row   = rs_op_reg.row - ROW_W'(1);
        res_up.col   = rs_op_reg.col;
        res_up.chan  = rs_op_reg.chan;
        res_up.done  = 1'b0;

        res_last.pixel = PIX_W'(sum_last >> SUM_SHIFT);
        res_last.row   = rs_op_reg.row;
        res_last.col   = rs_op_reg.col;
        res_last.chan  = rs_op_reg.chan;
        res_last.done  = rs_op_reg.done;
    end

    // ------------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------------
    always_comb
    begin
        push_up       = rs_valid_reg && rs_op_reg.emit_up;
        push_last     = rs_valid_reg && rs_op_reg.emit_last;
        n_push        = FIFO_CW'(push_up) + FIFO_CW'(push_last);
        pop           = out_valid && !out_stall;
        last_slot     = push_up ? FIFO_AW'(tail_reg + 1'b1) : tail_reg;
        tail_next     = FIFO_AW'(tail_reg + FIFO_AW'(n_push));
        head_next     = FIFO_AW'(head_reg + FIFO_AW'(pop));
        fifo_cnt_next = fifo_cnt_reg + n_push - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_up)
            fifo_mem_reg[tail_reg] <= res_up;
        if (push_last)
            fifo_mem_reg[last_slot] <= res_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    // drive the result port from the queue head
    assign head_res    = fifo_mem_reg[head_reg];
    assign out_valid   = (fifo_cnt_reg != '0);
    assign pixel_out   = head_res.pixel;
    assign out_row     = head_res.row;
    assign out_col     = head_res.col;
    assign out_channel = head_res.chan;
    assign frame_done  = head_res.done;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        hop1_valid_reg |-> hop0_valid_reg)
        else $error("second pending operation without a first");

    a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> rs_valid_reg)
        else $error("forwarded data into an empty write-back stage");

    a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> rs_valid_reg)
        else $error("issued operation lost before write-back");

endmodule
